FILE: rtl/s3if_pkg.sv
// Shared types and constants of the 3x3 sliding-window image filter.
// Used by the top level, the filter kernel and the port checker.
package s3if_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4095;

	localparam int PIX_W   = 8;
	localparam int CFG_DW  = 12;
	localparam int CFG_IW  = 2;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int IMGW_W  = 11;
	localparam int IMGH_W  = 12;

	localparam logic [IMGW_W-1:0] WIDTH_RST  = 11'd512;
	localparam logic [IMGH_W-1:0] HEIGHT_RST = 12'd512;

	// floor(S*0.11111) == (S*BOX_RECIP) >> BOX_SHIFT for every window sum
	localparam int BOX_RECIP  = 29127;
	localparam int BOX_SHIFT  = 18;
	// floor(x/3) for x below 1024
	localparam int DIV3_RECIP = 683;
	localparam int DIV3_SHIFT = 11;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		MODE_BOX      = 3'd0,
		MODE_GAUSS    = 3'd1,
		MODE_PREWITTX = 3'd2,
		MODE_PREWITTY = 3'd3,
		MODE_SOBELX   = 3'd4,
		MODE_SOBELY   = 3'd5,
		MODE_LAPLACE  = 3'd6,
		MODE_SHARPEN  = 3'd7
	} mode_t;

endpackage

FILE: rtl/s3if_kernel.sv
// 3x3 filter arithmetic: window in, filtered byte out, pure combinational.
// Depends on s3if_pkg.
module s3if_kernel import s3if_pkg::*; (
	input  mode_t mode,
	input  pix_t  win [9],
	output pix_t  result
);

	logic        [9:0]  col_l, col_r, row_t, row_b;
	logic        [9:0]  wl, wr, wt, wb;
	logic        [11:0] sum_all, gauss_sum, c9, c10;
	logic signed [11:0] dpx, dpy, dsx, dsy;
	logic signed [12:0] lap_v, shp_v;
	logic        [9:0]  a3;
	logic        [19:0] q3;
	logic        [25:0] qb;
	logic        [11:0] a_sx, a_sy, a_lap;

	function automatic logic [11:0] abs_val(input logic signed [12:0] v);
		return v[12] ? 12'(-v) : 12'(v);
	endfunction

	always_comb begin
		col_l = 10'(win[0]) + 10'(win[3]) + 10'(win[6]);
		col_r = 10'(win[2]) + 10'(win[5]) + 10'(win[8]);
		row_t = 10'(win[0]) + 10'(win[1]) + 10'(win[2]);
		row_b = 10'(win[6]) + 10'(win[7]) + 10'(win[8]);
		wl    = 10'(win[0]) + {1'b0, win[3], 1'b0} + 10'(win[6]);
		wr    = 10'(win[2]) + {1'b0, win[5], 1'b0} + 10'(win[8]);
		wt    = 10'(win[0]) + {1'b0, win[1], 1'b0} + 10'(win[2]);
		wb    = 10'(win[6]) + {1'b0, win[7], 1'b0} + 10'(win[8]);

		sum_all   = 12'(col_l) + 12'(col_r) + 12'(win[1]) + 12'(win[4]) + 12'(win[7]);
		gauss_sum = 12'(win[0]) + 12'(win[2]) + 12'(win[6]) + 12'(win[8])
			+ {3'b0, win[1], 1'b0} + {3'b0, win[3], 1'b0}
			+ {3'b0, win[5], 1'b0} + {3'b0, win[7], 1'b0}
			+ {2'b0, win[4], 2'b0};

		c9  = {1'b0, win[4], 3'b000} + 12'(win[4]);
		c10 = c9 + 12'(win[4]);

		dpx   = $signed({2'b0, col_r}) - $signed({2'b0, col_l});
		dpy   = $signed({2'b0, row_b}) - $signed({2'b0, row_t});
		dsx   = $signed({2'b0, wr}) - $signed({2'b0, wl});
		dsy   = $signed({2'b0, wb}) - $signed({2'b0, wt});
		lap_v = $signed({1'b0, c9}) - $signed({1'b0, sum_all});
		shp_v = $signed({1'b0, c10}) - $signed({1'b0, sum_all});

		a3    = (mode == MODE_PREWITTY) ? 10'(abs_val(13'(dpy))) : 10'(abs_val(13'(dpx)));
		q3    = 20'(a3) * 20'(DIV3_RECIP);
		qb    = 26'(sum_all) * 26'(BOX_RECIP);
		a_sx  = abs_val(13'(dsx));
		a_sy  = abs_val(13'(dsy));
		a_lap = abs_val(lap_v);

		case (mode)
			MODE_BOX:      result = 8'(qb >> BOX_SHIFT);
			MODE_GAUSS:    result = gauss_sum[11:4];
			MODE_PREWITTX: result = 8'(q3 >> DIV3_SHIFT);
			MODE_PREWITTY: result = 8'(q3 >> DIV3_SHIFT);
			MODE_SOBELX:   result = 8'(a_sx >> 2);
			MODE_SOBELY:   result = 8'(a_sy >> 2);
			MODE_LAPLACE:  result = 8'(a_lap >> 3);
			MODE_SHARPEN: begin
				if (shp_v[12])
					result = 8'd0;
				else if (shp_v > 13'sd255)
					result = 8'd255;
				else
					result = shp_v[7:0];
			end
			default:       result = 8'd0;
		endcase
	end

endmodule

FILE: rtl/sliding_3x3_image_filter_top.sv
// Top level of the streaming 3x3 image filter: line stores, window, counters, output register.
// Depends on s3if_pkg and s3if_kernel.
//
// Takes one 8-bit grey pixel per clock in raster order and, for every interior
// pixel, returns one filtered byte with its row, column and a last-of-frame
// flag; border pixels give no beat. A pixel goes from the line-store read into
// the window stage, then through the filter arithmetic into the output register.
// Throughput is one pixel per clock; the input only stalls while a result is held
// in the output register and out_ready is low. Geometry and mode are to be written
// through the config port only while the stream is idle; the block itself does not
// enforce this. A width or height write restarts the frame at row 0, column 0.
module sliding_3x3_image_filter_top import s3if_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  pixel_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  pixel_out,
	output logic [ROW_W-1:0]  center_row,
	output logic [COL_W-1:0]  center_col,
	output logic              frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [IMGW_W-1:0] width_q;
	logic [IMGH_W-1:0] height_q;
	mode_t             mode_q;
	logic              cfg_we, in_acc, adv1;
	logic [CW-1:0]     w_last, col_q;
	logic [RW-1:0]     h_last, row_q;

	logic              v_s1, emit_s1, last_s1;
	pix_t              pix_s1, top_s1, mid_s1;
	logic [CW-1:0]     col_s1;
	logic [RW-1:0]     row_s1;

	pix_t              store_a [MAX_WIDTH];
	pix_t              store_b [MAX_WIDTH];
	pix_t              win_q [6];
	pix_t              win9 [9];
	pix_t              filt;

	logic              out_valid_q, frame_last_q;
	pix_t              pixel_out_q;
	logic [ROW_W-1:0]  center_row_q;
	logic [COL_W-1:0]  center_col_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q   <= MODE_BOX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[IMGW_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[IMGH_W-1:0];
				REG_MODE:   mode_q   <= mode_t'(cfg_data[2:0]);
				default: ;
			endcase
		end
	end

	// clamped geometry, as last index
	always_comb begin
		if (width_q < 11'd3)
			w_last = CW'(2);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_last = CW'(MAX_WIDTH - 1);
		else
			w_last = CW'(width_q - 11'd1);

		if (height_q < 12'd3)
			h_last = RW'(2);
		else if (32'(height_q) > 32'(MAX_HEIGHT))
			h_last = RW'(MAX_HEIGHT - 1);
		else
			h_last = RW'(height_q - 12'd1);
	end

	assign adv1     = v_s1 & (~emit_s1 | ~out_valid_q | out_ready);
	assign in_ready = ~v_s1 | adv1;
	assign in_acc   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_acc)
			v_s1 <= 1'b1;
		else if (adv1)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel_in;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1 <= (row_q == h_last) && (col_q == w_last);
		end
	end

	// line stores: read on accept, written back when the beat leaves stage 1
	always_ff @(posedge clk) begin
		if (adv1)
			store_a[col_s1] <= pix_s1;
		if (in_acc)
			mid_s1 <= store_a[col_q];
	end

	always_ff @(posedge clk) begin
		if (adv1)
			store_b[col_s1] <= mid_s1;
		if (in_acc)
			top_s1 <= store_b[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (adv1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top_s1;
			win_q[2] <= win_q[3];
			win_q[3] <= mid_s1;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	always_comb begin
		win9[0] = win_q[0];
		win9[1] = win_q[1];
		win9[2] = top_s1;
		win9[3] = win_q[2];
		win9[4] = win_q[3];
		win9[5] = mid_s1;
		win9[6] = win_q[4];
		win9[7] = win_q[5];
		win9[8] = pix_s1;
	end

	s3if_kernel u_kernel (
		.mode   (mode_q),
		.win    (win9),
		.result (filt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv1 && emit_s1)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv1 && emit_s1) begin
			pixel_out_q  <= filt;
			center_row_q <= ROW_W'(row_s1 - RW'(1));
			center_col_q <= COL_W'(col_s1 - CW'(1));
			frame_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign center_row = center_row_q;
	assign center_col = center_col_q;
	assign frame_last = frame_last_q;

endmodule

FILE: rtl/s3if_checker.sv
// Port-level checks of the 3x3 image filter, bound to the top level.
// Depends on s3if_pkg and sliding_3x3_image_filter_top.
module s3if_checker import s3if_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PIX_W-1:0]  pixel_out,
	input logic [ROW_W-1:0]  center_row,
	input logic [COL_W-1:0]  center_col,
	input logic              frame_last
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out)
			&& $stable(center_row) && $stable(center_col) && $stable(frame_last))
		else $error("result beat changed while stalled");

	// results never name a pixel in row 0 or column 0
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> center_row != 12'd0 && center_col != 10'd0)
		else $error("result on a border pixel");

	// with the output register empty nothing may hold off the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a new result beat needs an earlier accepted input beat, or an input stall at that point
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 2))
		else $error("result beat without input beat");

endmodule

bind sliding_3x3_image_filter_top s3if_checker u_s3if_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_3x3_image_filter_top: streams grey frames
// through valid/ready, predicts every filtered centre pixel and checks each output beat.
// Depends on s3if_pkg and the RTL of the filter top level.
module testbench;
	import s3if_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int DRAIN_CYCLES  = 6;
	localparam int HOLD_CYCLES   = 400;
	localparam int RAND_ITEMS    = 200;
	localparam int MAX_REPORTS   = 10;
	localparam longint LIMIT_CYCLES = 3_000_000;
	localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

	typedef logic [8:0][PIX_W-1:0] nbhd_t;

	typedef struct packed {
		pix_t             value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} filt_result_t;

	typedef enum int {
		PAT_NOISE,
		PAT_EXTREME,
		PAT_SMOOTH,
		PAT_STEP
	} pattern_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  pixel_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PIX_W-1:0]  pixel_out;
	logic [ROW_W-1:0]  center_row;
	logic [COL_W-1:0]  center_col;
	logic              frame_last;

	// model of the block
	pix_t              line_a [DEF_MAX_WIDTH] = '{default: '0};
	pix_t              line_b [DEF_MAX_WIDTH] = '{default: '0};
	pix_t              win_cols [6] = '{default: '0};
	int                row_pos = 0;
	int                col_pos = 0;
	logic [IMGW_W-1:0] geom_w = WIDTH_RST;
	logic [IMGH_W-1:0] geom_h = HEIGHT_RST;
	mode_t             cur_mode = MODE_BOX;

	filt_result_t      filtered_px_q [$];
	filt_result_t      chk_want;

	int                fail_count = 0;
	int                pixels_sent = 0;
	int                results_seen = 0;
	int                reg_writes = 0;
	int                tx_quiet_left = 0;
	int                rx_stall_left = 0;
	int                rx_quiet_left = 0;
	int                rx_roll;
	int                last_pix = 128;
	logic              rx_hold = 1'b0;

	sliding_3x3_image_filter_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.center_row (center_row),
		.center_col (center_col),
		.frame_last (frame_last)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("timeout with %0d results outstanding", filtered_px_q.size());
		$display("testbench NOT OK");
		$finish;
	end

	function automatic int clamp_range(input int x, input int lo, input int hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	function automatic int magnitude(input int x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic pix_t filter_kernel(input nbhd_t n, input mode_t m);
		int p [9];
		int s;
		int v;
		int i;
		s = 0;
		for (i = 0; i < 9; i++) begin
			p[i] = int'(n[i]);
			s += p[i];
		end
		case (m)
		MODE_BOX: v = (s * 11111) / 100000;
		MODE_GAUSS: v = (p[0] + p[2] + p[6] + p[8] + 2 * (p[1] + p[3] + p[5] + p[7])
			+ 4 * p[4]) >> 4;
		MODE_PREWITTX: v = magnitude(p[2] + p[5] + p[8] - p[0] - p[3] - p[6]) / 3;
		MODE_PREWITTY: v = magnitude(p[6] + p[7] + p[8] - p[0] - p[1] - p[2]) / 3;
		MODE_SOBELX: v = magnitude(p[2] + 2 * p[5] + p[8] - p[0] - 2 * p[3] - p[6]) / 4;
		MODE_SOBELY: v = magnitude(p[6] + 2 * p[7] + p[8] - p[0] - 2 * p[1] - p[2]) / 4;
		MODE_LAPLACE: v = magnitude(9 * p[4] - s) / 8;
		default: begin
			v = clamp_range(10 * p[4] - s, 0, 255);
		end
		endcase
		return pix_t'(v);
	endfunction

	// one accepted pixel: shift line stores and window, queue the centre result of an interior window
	function automatic void advance_filter_model(input pix_t pin);
		int w;
		int h;
		int c;
		int r;
		pix_t top;
		pix_t mid;
		nbhd_t n;
		filt_result_t res;
		w = clamp_range(int'(geom_w), 3, DEF_MAX_WIDTH);
		h = clamp_range(int'(geom_h), 3, DEF_MAX_HEIGHT);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = row_pos;
		top = line_b[c];
		mid = line_a[c];
		line_b[c] = mid;
		line_a[c] = pin;
		n[0] = win_cols[0];
		n[1] = win_cols[1];
		n[2] = top;
		n[3] = win_cols[2];
		n[4] = win_cols[3];
		n[5] = mid;
		n[6] = win_cols[4];
		n[7] = win_cols[5];
		n[8] = pin;
		if (r >= 2 && c >= 2) begin
			res.value = filter_kernel(n, cur_mode);
			res.row = ROW_W'(r - 1);
			res.col = COL_W'(c - 1);
			res.last = (r == h - 1 && c == w - 1);
			filtered_px_q.push_back(res);
		end
		win_cols[0] = n[1];
		win_cols[1] = n[2];
		win_cols[2] = n[4];
		win_cols[3] = n[5];
		win_cols[4] = n[7];
		win_cols[5] = n[8];
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic int pick_gap();
		int roll;
		if (tx_quiet_left > 0) begin
			tx_quiet_left--;
			return 0;
		end
		roll = $urandom_range(0, 999);
		if (roll < 4) begin
			tx_quiet_left = $urandom_range(50, 200);
			return 0;
		end
		if (roll < 550)
			return 0;
		if (roll < 850)
			return $urandom_range(1, 3);
		if (roll < 970)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// output side: random stalls, quiet stretches, and the forced hold
	always @(posedge clk) begin
		if (rx_stall_left > 0) begin
			rx_stall_left--;
		end else if (rx_quiet_left > 0) begin
			rx_quiet_left--;
		end else begin
			rx_roll = $urandom_range(0, 999);
			if (rx_roll < 5)
				rx_quiet_left = $urandom_range(100, 400);
			else if (rx_roll < 300)
				rx_stall_left = $urandom_range(1, 3);
			else if (rx_roll < 330)
				rx_stall_left = $urandom_range(4, 12);
			else if (rx_roll < 336)
				rx_stall_left = $urandom_range(20, 60);
		end
		out_ready <= !rx_hold && (rx_stall_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (filtered_px_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected beat pix %0d row %0d col %0d last %0b", $realtime,
						pixel_out, center_row, center_col, frame_last);
			end else begin
				chk_want = filtered_px_q.pop_front();
				results_seen++;
				if (pixel_out !== chk_want.value || center_row !== chk_want.row
						|| center_col !== chk_want.col || frame_last !== chk_want.last) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: mismatch exp pix %0d row %0d col %0d last %0b, got pix %0d row %0d col %0d last %0b",
							$realtime, chk_want.value, chk_want.row, chk_want.col,
							chk_want.last, pixel_out, center_row, center_col, frame_last);
				end
			end
		end
	end

	task automatic send_pixel(input pix_t pix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (!in_ready);
		advance_filter_model(pix);
		pixels_sent++;
	endtask

	// stop offering pixels and wait until every predicted result has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (filtered_px_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
		REG_WIDTH: begin
			geom_w = data[IMGW_W-1:0];
			row_pos = 0;
			col_pos = 0;
		end
		REG_HEIGHT: begin
			geom_h = data[IMGH_W-1:0];
			row_pos = 0;
			col_pos = 0;
		end
		REG_MODE: begin
			cur_mode = mode_t'(data[2:0]);
		end
		default: begin
		end
		endcase
	endtask

	task automatic stream_pixels(input int count, input pattern_t pat);
		int lo;
		int hi;
		int ew;
		int i;
		pix_t pix;
		lo = $urandom_range(0, 255);
		hi = $urandom_range(0, 255);
		for (i = 0; i < count; i++) begin
			ew = clamp_range(int'(geom_w), 3, DEF_MAX_WIDTH);
			case (pat)
			PAT_EXTREME: pix = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
			PAT_SMOOTH: begin
				last_pix = clamp_range(last_pix + int'($urandom_range(0, 16)) - 8, 0, 255);
				pix = pix_t'(last_pix);
			end
			PAT_STEP: pix = pix_t'((col_pos < ew / 2) ? lo : hi);
			default: pix = pix_t'($urandom_range(0, 255));
			endcase
			send_pixel(pix);
		end
	endtask

	// registers left at reset: 512 wide, box filter
	task automatic test_reset_geometry();
		stream_pixels(2 * 512 + 8, PAT_NOISE);
	endtask

	// one small frame of saturated rows, a different filter for each interior pixel
	task automatic test_directed_extremes();
		int c;
		write_reg(REG_WIDTH, 12'd10);
		write_reg(REG_HEIGHT, 12'd3);
		write_reg(REG_MODE, 12'(MODE_BOX));
		for (c = 0; c < 10; c++)
			send_pixel(8'd255);
		for (c = 0; c < 10; c++)
			send_pixel(c[0] ? 8'd255 : 8'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		for (c = 2; c < 10; c++) begin
			write_reg(REG_MODE, 12'(c - 2));
			send_pixel(c[0] ? 8'd255 : 8'd0);
		end
	endtask

	// out-of-range and masked geometry values, start of the widest row
	task automatic test_clamped_geometry();
		write_reg(REG_WIDTH, 12'hFFF);
		write_reg(REG_HEIGHT, 12'd0);
		write_reg(REG_MODE, 12'(MODE_LAPLACE));
		stream_pixels(64, PAT_NOISE);
		write_reg(REG_WIDTH, 12'd1);
		write_reg(REG_HEIGHT, 12'hFFF);
		write_reg(REG_MODE, 12'(MODE_SHARPEN));
		stream_pixels(60, PAT_EXTREME);
		write_reg(REG_WIDTH, 12'd2);
		write_reg(REG_HEIGHT, 12'd2);
		stream_pixels(18, PAT_NOISE);
		write_reg(REG_WIDTH, 12'd30);
		write_reg(REG_HEIGHT, 12'd3);
		write_reg(REG_MODE, 12'(MODE_GAUSS));
		stream_pixels(30 * 3 + 10, PAT_STEP);
	endtask

	// mode change, ignored index and geometry restart, all inside a frame
	task automatic test_mid_frame_writes();
		write_reg(REG_WIDTH, 12'd12);
		write_reg(REG_HEIGHT, 12'd6);
		write_reg(REG_MODE, 12'(MODE_PREWITTX));
		stream_pixels(40, PAT_NOISE);
		write_reg(REG_MODE, 12'h8 | 12'(MODE_PREWITTY));
		stream_pixels(30, PAT_SMOOTH);
		write_reg(REG_NONE, 12'($urandom_range(0, 4095)));
		stream_pixels(20, PAT_NOISE);
		write_reg(REG_NONE, 12'hFFF);
		stream_pixels(7, PAT_NOISE);
		write_reg(REG_WIDTH, 12'd9);
		stream_pixels(9 * 6 + 13, PAT_NOISE);
		write_reg(REG_HEIGHT, 12'd4);
		stream_pixels(9 * 4 * 2, PAT_EXTREME);
	endtask

	// receiver holds off long enough to fill the block and stall the input
	task automatic test_output_stall();
		write_reg(REG_WIDTH, 12'd20);
		write_reg(REG_HEIGHT, 12'd6);
		write_reg(REG_MODE, 12'(MODE_SOBELY));
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		stream_pixels(120, PAT_NOISE);
	endtask

	// sender stops mid-frame until all results are out, then resumes
	task automatic test_sender_pause();
		write_reg(REG_WIDTH, 12'd14);
		write_reg(REG_HEIGHT, 12'd5);
		write_reg(REG_MODE, 12'(MODE_SOBELX));
		stream_pixels(37, PAT_NOISE);
		drain();
		stream_pixels(60, PAT_SMOOTH);
		drain();
		stream_pixels(40, PAT_NOISE);
	endtask

	task automatic test_random_frames();
		int rand_px;
		int w;
		int h;
		int ew;
		int eh;
		int frame_px;
		int count;
		int split;
		int roll;
		logic [CFG_DW-1:0] wdata;
		pattern_t pat;
		rand_px = 0;
		while (rand_px < RAND_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				w = $urandom_range(0, 2);
			else if (roll < 80)
				w = $urandom_range(3, 12);
			else
				w = $urandom_range(13, 30);
			roll = $urandom_range(0, 99);
			if (roll < 10)
				h = $urandom_range(0, 2);
			else
				h = $urandom_range(3, 6);
			wdata = 12'(w);
			wdata[CFG_DW-1] = $urandom_range(0, 1);
			write_reg(REG_WIDTH, wdata);
			write_reg(REG_HEIGHT, 12'(h));
			write_reg(REG_MODE, 12'($urandom_range(0, 4095)));
			pat = pattern_t'($urandom_range(0, 3));
			ew = clamp_range(w, 3, DEF_MAX_WIDTH);
			eh = clamp_range(h, 3, DEF_MAX_HEIGHT);
			frame_px = ew * eh;
			count = frame_px * $urandom_range(1, 2);
			if ($urandom_range(0, 2) == 0)
				count += $urandom_range(0, frame_px - 1);
			if (count > RAND_ITEMS - rand_px)
				count = RAND_ITEMS - rand_px;
			if (count > 1 && $urandom_range(0, 2) == 0) begin
				split = $urandom_range(1, count - 1);
				stream_pixels(split, pat);
				write_reg(REG_MODE, 12'($urandom_range(0, 4095)));
				stream_pixels(count - split, pat);
			end else begin
				stream_pixels(count, pat);
			end
			rand_px += count;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_directed_extremes();
		test_clamped_geometry();
		test_mid_frame_writes();
		test_output_stall();
		test_sender_pause();
		test_random_frames();
		drain();
		$display("sent %0d pixels over directed and random frames, checked %0d filtered beats",
			pixels_sent, results_seen);
		$display("%0d register writes, %0d failures", reg_writes, fail_count);
		if (fail_count == 0 && filtered_px_q.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/s3if_pkg.sv
rtl/s3if_kernel.sv
rtl/sliding_3x3_image_filter_top.sv
rtl/s3if_checker.sv
sim/testbench.sv
